@@ design/hdbn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HDBn line encoder package
// Shared widths, symbol codes, register indexes and payload types.
// ----------------------------------------------------------------------------
package hdbn_pkg;

  // Largest supported code order and the symbol line that follows from it
  localparam int MAX_ORDER  = 7;
  localparam int LINE_DEPTH = MAX_ORDER + 1;
  localparam int FILL_W     = $clog2(LINE_DEPTH + 1);
  localparam int RUN_W      = 4;
  localparam int ORDER_W    = 3;

  // Output skid buffer
  localparam int SKID_DEPTH = 2;
  localparam int SKID_PTR_W = $clog2(SKID_DEPTH);
  localparam int SKID_CNT_W = $clog2(SKID_DEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = ORDER_W;

  localparam logic [CFG_IDX_W-1:0] REG_CODE_ORDER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_PULSE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_VIOL  = 2'd2;

  // Reset values of the configuration registers
  localparam logic [ORDER_W-1:0] CODE_ORDER_RST = 3'd3;

  // Item modes
  localparam logic MODE_PUSH  = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // Bipolar symbol held in the line
  typedef enum logic [1:0] {
    SYM_ZERO = 2'd0,
    SYM_POS  = 2'd1,
    SYM_NEG  = 2'd2
  } sym_t;

  // Input item
  typedef struct packed {
    logic mode;
    logic data_bit;
  } bit_item_t;

  // Result item
  typedef struct packed {
    logic pos_pulse;
    logic neg_pulse;
    logic last_of_run;
  } sym_item_t;

endpackage

@@ design/hdbn_bit_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HDBn input channel
// Valid/ready channel carrying one data bit or a flush request.
// ----------------------------------------------------------------------------
interface hdbn_bit_if;
  logic                 valid;
  logic                 ready;
  hdbn_pkg::bit_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/hdbn_sym_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HDBn output channel
// Valid/ready channel carrying one bipolar symbol on two rails.
// ----------------------------------------------------------------------------
interface hdbn_sym_if;
  logic                 valid;
  logic                 ready;
  hdbn_pkg::sym_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/hdbn_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HDBn coder core
// Holds the accepted item, the symbol line and the polarity state. Each cycle
// it may emit the oldest symbol and, once no more pops are owed, applies the
// item: a push codes the bit (with run substitution), a flush restarts.
// ----------------------------------------------------------------------------
module hdbn_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [hdbn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hdbn_pkg::CFG_DATA_W-1:0]     cfg_data,
  hdbn_bit_if.sink                            bits,
  input  logic                                emit_space,
  output logic                                emit_en,
  output hdbn_pkg::sym_item_t                 emit_item
);

  // Configuration registers
  logic [hdbn_pkg::ORDER_W-1:0] code_order;
  logic                         start_pulse_negative;
  logic                         start_violation_negative;

  // Held item
  logic                         item_valid;
  hdbn_pkg::bit_item_t          item;

  // Coder state
  hdbn_pkg::sym_t               symbol_line [hdbn_pkg::LINE_DEPTH];
  hdbn_pkg::sym_t               line_next   [hdbn_pkg::LINE_DEPTH];
  hdbn_pkg::sym_t               shifted     [hdbn_pkg::LINE_DEPTH];
  logic [hdbn_pkg::FILL_W-1:0]  line_fill;
  logic [hdbn_pkg::RUN_W-1:0]   zero_run;
  logic                         last_pulse_negative;
  logic                         last_violation_negative;

  // Working signals
  logic [hdbn_pkg::FILL_W-1:0]  eff_n;
  logic [hdbn_pkg::FILL_W-1:0]  fill_after;
  logic [hdbn_pkg::FILL_W-1:0]  bpos;
  logic [hdbn_pkg::RUN_W-1:0]   run_inc;
  logic                         is_flush;
  logic                         need_pop;
  logic                         pop_en;
  logic                         item_done;
  logic                         subst;
  logic                         b_needed;
  hdbn_pkg::sym_t               mark_sym;
  hdbn_pkg::sym_t               viol_sym;
  hdbn_pkg::sym_t               new_sym;

  // Configuration writes; indexes past the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      code_order               <= hdbn_pkg::CODE_ORDER_RST;
      start_pulse_negative     <= 1'b0;
      start_violation_negative <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hdbn_pkg::REG_CODE_ORDER:  code_order               <= cfg_data;
        hdbn_pkg::REG_START_PULSE: start_pulse_negative     <= cfg_data[0];
        hdbn_pkg::REG_START_VIOL:  start_violation_negative <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective order, clamped to 1..MAX_ORDER
  always_comb begin
    if (code_order == '0) begin
      eff_n = hdbn_pkg::FILL_W'(1);
    end else if (hdbn_pkg::FILL_W'(code_order) > hdbn_pkg::FILL_W'(hdbn_pkg::MAX_ORDER)) begin
      eff_n = hdbn_pkg::FILL_W'(hdbn_pkg::MAX_ORDER);
    end else begin
      eff_n = hdbn_pkg::FILL_W'(code_order);
    end
  end

  // Pop control: a flush drains everything, a push trims the line to n
  assign is_flush   = (item.mode == hdbn_pkg::MODE_FLUSH);
  assign need_pop   = is_flush ? (line_fill != '0) : (line_fill > eff_n);
  assign pop_en     = item_valid && need_pop && emit_space;
  assign fill_after = line_fill - hdbn_pkg::FILL_W'(pop_en);
  assign item_done  = item_valid &&
                      (is_flush ? (fill_after == '0) : (fill_after <= eff_n));

  // Accept a new item when idle or while the current one is finished this cycle
  assign bits.ready = !item_valid || item_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (bits.valid && bits.ready) begin
      item_valid <= 1'b1;
    end else if (item_done) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bits.valid && bits.ready) begin
      item <= bits.data;
    end
  end

  // Oldest symbol out
  assign emit_en               = pop_en;
  assign emit_item.pos_pulse   = (symbol_line[0] == hdbn_pkg::SYM_POS);
  assign emit_item.neg_pulse   = (symbol_line[0] == hdbn_pkg::SYM_NEG);
  assign emit_item.last_of_run = is_flush && (line_fill == hdbn_pkg::FILL_W'(1));

  // Symbol coding for a push
  assign run_inc  = (zero_run == '1) ? zero_run : zero_run + 1'b1;
  assign mark_sym = last_pulse_negative ? hdbn_pkg::SYM_POS : hdbn_pkg::SYM_NEG;
  assign viol_sym = last_violation_negative ? hdbn_pkg::SYM_POS : hdbn_pkg::SYM_NEG;
  assign subst    = !item.data_bit &&
                    ({1'b0, run_inc} >= {1'b0, hdbn_pkg::RUN_W'(eff_n)} + 1'b1) &&
                    ({1'b0, fill_after} >= {1'b0, eff_n});
  assign b_needed = (last_pulse_negative == last_violation_negative);
  assign bpos     = fill_after - eff_n;

  always_comb begin
    if (item.data_bit) begin
      new_sym = mark_sym;
    end else if (subst) begin
      new_sym = viol_sym;
    end else begin
      new_sym = hdbn_pkg::SYM_ZERO;
    end
  end

  // Line after the optional pop, then the insertion and balancing pulse
  always_comb begin
    for (int i = 0; i < hdbn_pkg::LINE_DEPTH; i++) begin
      if (!pop_en) begin
        shifted[i] = symbol_line[i];
      end else if (i + 1 < hdbn_pkg::LINE_DEPTH) begin
        shifted[i] = symbol_line[i + 1];
      end else begin
        shifted[i] = hdbn_pkg::SYM_ZERO;
      end
    end
    for (int i = 0; i < hdbn_pkg::LINE_DEPTH; i++) begin
      line_next[i] = shifted[i];
      if (item_done && !is_flush) begin
        if (hdbn_pkg::FILL_W'(i) == fill_after) begin
          line_next[i] = new_sym;
        end else if (subst && (hdbn_pkg::FILL_W'(i) == bpos)) begin
          line_next[i] = b_needed ? viol_sym : hdbn_pkg::SYM_ZERO;
        end
      end
    end
  end

  // Coder state update
  always_ff @(posedge clk) begin
    if (rst) begin
      line_fill               <= '0;
      zero_run                <= '0;
      last_pulse_negative     <= 1'b0;
      last_violation_negative <= 1'b0;
      for (int i = 0; i < hdbn_pkg::LINE_DEPTH; i++) begin
        symbol_line[i] <= hdbn_pkg::SYM_ZERO;
      end
    end else if (item_done && is_flush) begin
      line_fill               <= '0;
      zero_run                <= '0;
      last_pulse_negative     <= start_pulse_negative;
      last_violation_negative <= start_violation_negative;
      for (int i = 0; i < hdbn_pkg::LINE_DEPTH; i++) begin
        symbol_line[i] <= hdbn_pkg::SYM_ZERO;
      end
    end else if (item_done) begin
      line_fill   <= fill_after + 1'b1;
      symbol_line <= line_next;
      if (item.data_bit) begin
        zero_run            <= '0;
        last_pulse_negative <= !last_pulse_negative;
      end else if (subst) begin
        zero_run                <= '0;
        last_pulse_negative     <= !last_violation_negative;
        last_violation_negative <= !last_violation_negative;
      end else begin
        zero_run <= run_inc;
      end
    end else if (item_valid) begin
      line_fill   <= fill_after;
      symbol_line <= line_next;
    end
  end

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    line_fill <= hdbn_pkg::FILL_W'(hdbn_pkg::LINE_DEPTH))
    else $error("symbol line overfilled");

  a_pop_space: assert property (@(posedge clk) disable iff (rst)
    emit_en |-> emit_space)
    else $error("symbol emitted without skid space");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (item_done && is_flush) |=> (line_fill == '0) && (zero_run == '0))
    else $error("flush left symbols in the line");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (item_done && !is_flush) |=> (line_fill != '0))
    else $error("push left the line empty");

endmodule

@@ design/hdbn_out_skid.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HDBn output skid buffer
// Two-entry queue between the coder and the output channel, so the coder's
// pop decision depends only on registered occupancy.
// ----------------------------------------------------------------------------
module hdbn_out_skid (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  hdbn_pkg::sym_item_t  wr_item,
  output logic                 space,
  hdbn_sym_if.source           symbols
);

  hdbn_pkg::sym_item_t                entries [hdbn_pkg::SKID_DEPTH];
  logic [hdbn_pkg::SKID_PTR_W-1:0]    wr_ptr;
  logic [hdbn_pkg::SKID_PTR_W-1:0]    rd_ptr;
  logic [hdbn_pkg::SKID_CNT_W-1:0]    count;
  logic                               rd_en;

  assign space         = (count != hdbn_pkg::SKID_CNT_W'(hdbn_pkg::SKID_DEPTH));
  assign symbols.valid = (count != '0);
  assign symbols.data  = entries[rd_ptr];
  assign rd_en         = symbols.valid && symbols.ready;

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == hdbn_pkg::SKID_PTR_W'(hdbn_pkg::SKID_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == hdbn_pkg::SKID_PTR_W'(hdbn_pkg::SKID_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      count <= count + hdbn_pkg::SKID_CNT_W'(wr_en) - hdbn_pkg::SKID_CNT_W'(rd_en);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= hdbn_pkg::SKID_CNT_W'(hdbn_pkg::SKID_DEPTH))
    else $error("skid buffer overflow");

  a_write_space: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> space)
    else $error("write into full skid buffer");

  a_count_grow: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !rd_en) |=> (count == $past(count) + 1'b1))
    else $error("skid occupancy did not grow on write");

endmodule

@@ design/hdbn_line_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HDBn line encoder
// Codes one binary bit per transfer into bipolar symbols with HDBn run
// substitution of configurable order, delayed through an (n+1)-symbol line.
//
//   channel  | role   | payload                           | transfer
//   bits     | sink   | mode, data_bit                    | valid && ready
//   symbols  | source | pos_pulse, neg_pulse, last_of_run | valid && ready
//   cfg      | write  | cfg_index, cfg_data               | cfg_we
//
// One push item per cycle is sustained while the output takes symbols; a push
// is held in the item register, and the symbol it displaces then in the skid buffer.
// A flush drains the line one symbol at a time (up to 8) through the single
// read port at the head of the line; an empty flush only restarts the coder.
// Reset is synchronous and clears the line and polarity state at once.
// A stalled output fills the two-entry skid buffer, then holds bits.ready low.
// ----------------------------------------------------------------------------
module hdbn_line_encoder (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [hdbn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hdbn_pkg::CFG_DATA_W-1:0]  cfg_data,
  hdbn_bit_if.sink                         bits,
  hdbn_sym_if.source                       symbols
);

  logic                 emit_en;
  logic                 emit_space;
  hdbn_pkg::sym_item_t  emit_item;

  // Coder with item register and symbol line
  hdbn_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .bits       (bits),
    .emit_space (emit_space),
    .emit_en    (emit_en),
    .emit_item  (emit_item)
  );

  // Output skid stage
  hdbn_out_skid u_skid (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (emit_en),
    .wr_item (emit_item),
    .space   (emit_space),
    .symbols (symbols)
  );

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HDBn line encoder testbench
// Drives bits and flushes through the input channel under random stalls,
// predicts the bipolar symbol stream with its own coder model across several
// orders and start polarities, and checks every symbol transfer in order.
// ----------------------------------------------------------------------------
module testbench;

  // Coder model and store of symbols still owed by the block
  class line_code_board;
    logic [hdbn_pkg::ORDER_W-1:0] code_order;
    logic                         start_pulse_neg;
    logic                         start_viol_neg;
    hdbn_pkg::sym_t               line_syms [hdbn_pkg::LINE_DEPTH];
    int unsigned                  fill;
    int unsigned                  zeros_seen;
    logic                         pulse_neg;
    logic                         viol_neg;
    hdbn_pkg::sym_item_t          pending_symbols [$];
    int unsigned                  mismatches;

    function new();
      code_order      = hdbn_pkg::CODE_ORDER_RST;
      start_pulse_neg = 1'b0;
      start_viol_neg  = 1'b0;
      mismatches      = 0;
      restart();
    endfunction

    function void restart();
      foreach (line_syms[i]) line_syms[i] = hdbn_pkg::SYM_ZERO;
      fill       = 0;
      zeros_seen = 0;
      pulse_neg  = start_pulse_neg;
      viol_neg   = start_viol_neg;
    endfunction

    function void write_reg(logic [hdbn_pkg::CFG_IDX_W-1:0] idx,
                            logic [hdbn_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        hdbn_pkg::REG_CODE_ORDER:  code_order = val;
        hdbn_pkg::REG_START_PULSE: start_pulse_neg = val[0];
        hdbn_pkg::REG_START_VIOL:  start_viol_neg = val[0];
        default: ;
      endcase
    endfunction

    // Head of the line leaves as an expected symbol
    function void emit_head(logic last);
      hdbn_pkg::sym_item_t r;
      r.pos_pulse   = (line_syms[0] == hdbn_pkg::SYM_POS);
      r.neg_pulse   = (line_syms[0] == hdbn_pkg::SYM_NEG);
      r.last_of_run = last;
      pending_symbols.push_back(r);
      for (int i = 1; i < hdbn_pkg::LINE_DEPTH; i++) line_syms[i-1] = line_syms[i];
      line_syms[hdbn_pkg::LINE_DEPTH-1] = hdbn_pkg::SYM_ZERO;
      fill--;
    endfunction

    function void note_bit(hdbn_pkg::bit_item_t it);
      int unsigned    n;
      hdbn_pkg::sym_t pol;
      n = (code_order == 0) ? 1 : code_order;
      if (n > hdbn_pkg::MAX_ORDER) n = hdbn_pkg::MAX_ORDER;
      if (it.mode == hdbn_pkg::MODE_FLUSH) begin
        while (fill > 0) emit_head(fill == 1);
        restart();
      end else begin
        while (fill > n) emit_head(1'b0);
        if (it.data_bit) begin
          // mark: alternate polarity
          line_syms[fill] = pulse_neg ? hdbn_pkg::SYM_POS : hdbn_pkg::SYM_NEG;
          pulse_neg       = !pulse_neg;
          zeros_seen      = 0;
          fill++;
        end else begin
          line_syms[fill] = hdbn_pkg::SYM_ZERO;
          fill++;
          zeros_seen++;
          // n+1 zeros: V at the end, B at the start when polarity calls
          if (zeros_seen >= n + 1 && fill >= n + 1) begin
            pol = viol_neg ? hdbn_pkg::SYM_POS : hdbn_pkg::SYM_NEG;
            line_syms[fill-1-n] = (pulse_neg == viol_neg) ? pol : hdbn_pkg::SYM_ZERO;
            line_syms[fill-1]   = pol;
            viol_neg   = (pol == hdbn_pkg::SYM_NEG);
            pulse_neg  = viol_neg;
            zeros_seen = 0;
          end
        end
      end
    endfunction

    function void check_field(string name, logic want, logic got);
      if (got !== want) begin
        $display("%0t: %s expected %b, got %b", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_symbol(hdbn_pkg::sym_item_t got);
      hdbn_pkg::sym_item_t want;
      if (pending_symbols.size() == 0) begin
        $display("%0t: symbol expected none, got pos=%b neg=%b last=%b", $time,
                 got.pos_pulse, got.neg_pulse, got.last_of_run);
        mismatches++;
      end else begin
        want = pending_symbols.pop_front();
        check_field("pos_pulse", want.pos_pulse, got.pos_pulse);
        check_field("neg_pulse", want.neg_pulse, got.neg_pulse);
        check_field("last_of_run", want.last_of_run, got.last_of_run);
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we;
  logic [hdbn_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [hdbn_pkg::CFG_DATA_W-1:0] cfg_data;
  bit                              steady;

  hdbn_bit_if bits ();
  hdbn_sym_if symbols ();

  line_code_board board;

  hdbn_line_encoder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .bits      (bits),
    .symbols   (symbols)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Symbol side: check each transfer, stall at random
  always @(posedge clk) begin
    if (!rst && symbols.valid === 1'b1 && symbols.ready === 1'b1)
      board.check_symbol(symbols.data);
    symbols.ready <= steady || ($urandom_range(99) >= 25);
  end

  // One bit or flush transfer, with random gaps ahead of it
  task automatic send_item(logic mode, logic data_bit);
    hdbn_pkg::bit_item_t it;
    it.mode     = mode;
    it.data_bit = data_bit;
    while (!steady && $urandom_range(99) < 25) begin
      bits.valid <= 1'b0;
      @(posedge clk);
    end
    bits.valid <= 1'b1;
    bits.data  <= it;
    do @(posedge clk); while (bits.ready !== 1'b1);
    board.note_bit(it);
  endtask

  task automatic push_bits(logic [15:0] pattern, int count);
    for (int i = count - 1; i >= 0; i--) send_item(hdbn_pkg::MODE_PUSH, pattern[i]);
  endtask

  // Hold off until every owed symbol has arrived, then let the block settle
  task automatic drain(int settle);
    bits.valid <= 1'b0;
    while (board.pending_symbols.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Write all three registers while the block is idle
  task automatic load_setup(logic [hdbn_pkg::ORDER_W-1:0] order, logic pulse_neg,
                            logic viol_neg);
    drain(12);
    cfg_we    <= 1'b1;
    cfg_index <= hdbn_pkg::REG_CODE_ORDER;
    cfg_data  <= order;
    @(posedge clk);
    board.write_reg(hdbn_pkg::REG_CODE_ORDER, order);
    cfg_index <= hdbn_pkg::REG_START_PULSE;
    cfg_data  <= {2'b00, pulse_neg};
    @(posedge clk);
    board.write_reg(hdbn_pkg::REG_START_PULSE, {2'b00, pulse_neg});
    cfg_index <= hdbn_pkg::REG_START_VIOL;
    cfg_data  <= {2'b00, viol_neg};
    @(posedge clk);
    board.write_reg(hdbn_pkg::REG_START_VIOL, {2'b00, viol_neg});
    cfg_we    <= 1'b0;
  endtask

  // Stimulus
  initial begin
    logic [hdbn_pkg::ORDER_W-1:0] order;
    int                           zero_bias;
    board      = new();
    bits.valid = 1'b0;
    bits.data  = '0;
    cfg_we     = 1'b0;
    cfg_index  = hdbn_pkg::REG_CODE_ORDER;
    cfg_data   = '0;
    steady     = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // order 3 from reset: run with balancing pulse, then one without
    push_bits(16'b11000010000, 11);
    send_item(hdbn_pkg::MODE_FLUSH, 1'b1);

    // order 0 acts as 1; negative start polarities loaded by an empty flush
    load_setup(3'd0, 1'b1, 1'b1);
    send_item(hdbn_pkg::MODE_FLUSH, 1'b0);
    push_bits(16'b00100, 5);
    send_item(hdbn_pkg::MODE_FLUSH, 1'b0);

    // fill a line of eight, then lower the order to spill it in one push
    load_setup(3'd7, 1'b0, 1'b1);
    push_bits(16'hFF, 8);
    load_setup(3'd1, 1'b0, 1'b1);
    send_item(hdbn_pkg::MODE_PUSH, 1'b0);
    send_item(hdbn_pkg::MODE_FLUSH, 1'b0);

    // random phases, zero density varies to get long runs
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       order = 3'd7;
        1:       order = 3'd0;
        2:       order = 3'd1;
        default: order = hdbn_pkg::ORDER_W'($urandom_range(7));
      endcase
      load_setup(order, 1'($urandom_range(1)), 1'($urandom_range(1)));
      steady    <= (p == 3);
      zero_bias = 40 + 15 * $urandom_range(3);
      for (int k = 0; k < 36; k++) begin
        if (p == 5 && k == 18) drain(0);
        if ($urandom_range(99) < 4)
          send_item(hdbn_pkg::MODE_FLUSH, 1'($urandom_range(1)));
        else
          send_item(hdbn_pkg::MODE_PUSH, $urandom_range(99) >= zero_bias);
      end
    end
    steady <= 1'b0;
    send_item(hdbn_pkg::MODE_FLUSH, 1'($urandom_range(1)));
    drain(20);

    if (board.mismatches == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
